### sv/ppi_pkg.sv
// Package for the periodic profile interpolator.
// Holds field widths, register and kind codes, iteration counts and the
// command and status structs shared by the controller and the datapath.
package ppi_pkg;

	localparam int POS_W = 31;
	localparam int LEN_W = 31;
	localparam int VAL_W = 32;
	localparam int QRY_W = 32;
	localparam int CNT_W = 7;
	localparam int IDX_W = 6;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 31;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TRACK_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT   = 1'b1;

	// Input item kinds.
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// A loop this short or shorter marks the table invalid.
	localparam logic [LEN_W-1:0] MIN_TRACK_LENGTH = 31'd256;

	// Iteration counts of the sequential units.
	localparam int MOD_STEPS = 32;
	localparam int MUL_STEPS = 31;
	localparam int DIV_STEPS = 33;
	localparam int STEP_W = 6;

	// Source of the values loaded into the output register.
	typedef enum logic [1:0] {
		RES_ZERO,
		RES_FIRST,
		RES_LOWER,
		RES_LERP
	} ppi_res_src_t;

	typedef struct packed {
		logic         load_wr;
		logic         qry_start;
		logic         mod_step;
		logic         mod_fix;
		logic         mem_rd;
		logic         cmp_take;
		logic         idx_inc;
		logic         setup;
		logic         mul_init;
		logic         mul_step;
		logic         div_init;
		logic         div_step;
		logic         res_load;
		ppi_res_src_t res_src;
	} ppi_cmd_t;

	typedef struct packed {
		logic is_load;
		logic tbl_ok;
		logic gt;
		logic idx_first;
		logic idx_last;
		logic span_ok;
	} ppi_sts_t;

endpackage

### sv/ppi_ctrl.sv
// Controller of the periodic profile interpolator.
// Sequences loads, the wrap, the node scan, the multiply and the divide.
// Depends on ppi_pkg for the command and status structs.
module ppi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  ppi_pkg::ppi_sts_t  sts,
	output ppi_pkg::ppi_cmd_t  cmd
);
	import ppi_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MOD    = 4'd1;
	localparam logic [3:0] S_MODFIX = 4'd2;
	localparam logic [3:0] S_RD     = 4'd3;
	localparam logic [3:0] S_CMP    = 4'd4;
	localparam logic [3:0] S_SETUP  = 4'd5;
	localparam logic [3:0] S_CHK    = 4'd6;
	localparam logic [3:0] S_MUL    = 4'd7;
	localparam logic [3:0] S_DINIT  = 4'd8;
	localparam logic [3:0] S_DIV    = 4'd9;
	localparam logic [3:0] S_FIN    = 4'd10;

	logic [3:0]        state_q, state_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	ppi_res_src_t      src_q, src_d;
	logic              out_valid_q;
	logic              in_acc;
	logic              out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		src_d   = src_q;
		cmd     = '0;
		cmd.res_src = src_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (sts.is_load) begin
						cmd.load_wr = 1'b1;
					end else if (!sts.tbl_ok) begin
						src_d   = RES_ZERO;
						state_d = S_FIN;
					end else begin
						cmd.qry_start = 1'b1;
						cnt_d   = '0;
						state_d = S_MOD;
					end
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == STEP_W'(MOD_STEPS - 1)) begin
					state_d = S_MODFIX;
				end
			end
			S_MODFIX: begin
				cmd.mod_fix = 1'b1;
				state_d = S_RD;
			end
			S_RD: begin
				cmd.mem_rd = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.cmp_take = 1'b1;
				if (sts.gt) begin
					if (sts.idx_first) begin
						src_d   = RES_FIRST;
						state_d = S_FIN;
					end else begin
						state_d = S_SETUP;
					end
				end else if (sts.idx_last) begin
					state_d = S_SETUP;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = S_RD;
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (!sts.span_ok) begin
					src_d   = RES_LOWER;
					state_d = S_FIN;
				end else begin
					cmd.mul_init = 1'b1;
					cnt_d   = '0;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == STEP_W'(MUL_STEPS - 1)) begin
					state_d = S_DINIT;
				end
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				cnt_d   = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
					src_d   = RES_LERP;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, counter and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			src_q       <= RES_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			src_q   <= src_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### sv/ppi_dp.sv
// Datapath of the periodic profile interpolator.
// Holds the configuration, the node memory, the wrap divider, the scan
// registers, two shift-add multipliers, two dividers and the output register.
module ppi_dp #(
	parameter int MAX_NODES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ppi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ppi_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              kind,
	input  logic [ppi_pkg::IDX_W-1:0]         node_index,
	input  logic [ppi_pkg::POS_W-1:0]         node_position,
	input  logic signed [ppi_pkg::VAL_W-1:0]  node_curvature,
	input  logic signed [ppi_pkg::VAL_W-1:0]  node_elevation,
	input  logic signed [ppi_pkg::QRY_W-1:0]  query_position,
	output logic                              ok,
	output logic signed [ppi_pkg::VAL_W-1:0]  curvature_out,
	output logic signed [ppi_pkg::VAL_W-1:0]  elevation_out,
	input  ppi_pkg::ppi_cmd_t                 cmd,
	output ppi_pkg::ppi_sts_t                 sts
);
	import ppi_pkg::*;

	localparam int AW    = $clog2(MAX_NODES);
	localparam int CW    = $clog2(MAX_NODES + 1);
	localparam int ENT_W = POS_W + 2 * VAL_W;

	logic [LEN_W-1:0]  track_len_q;
	logic [CNT_W-1:0]  node_cnt_q;
	logic [CW-1:0]     n_eff;

	logic [ENT_W-1:0]  mem_q [MAX_NODES];
	logic [ENT_W-1:0]  rdata_q, e0_q, prev_q;
	logic [CW-1:0]     idx_q;
	logic              slot_ok;

	logic              qneg_q;
	logic [QRY_W-1:0]  mdq_q;
	logic [LEN_W-1:0]  mrem_q;
	logic [LEN_W:0]    mod_t;
	logic [LEN_W-1:0]  s_q;

	logic [POS_W:0]    up_pos_q;
	logic [VAL_W-1:0]  up_c_q, up_e_q;
	logic [POS_W-1:0]  r_pos, p_pos, e0_pos;
	logic [VAL_W-1:0]  r_c, r_e, p_c, p_e, e0_c, e0_e;

	logic [VAL_W:0]    span_q, span_w, dv_c, dv_e;
	logic [POS_W-1:0]  off_q, mpl_q;
	logic              neg_c_q, neg_e_q;
	logic [VAL_W:0]    mag_c_q, mag_e_q;
	logic [63:0]       acc_c_q, acc_e_q, mc_c_q, mc_e_q;
	logic [VAL_W:0]    rem_c_q, rem_e_q, dq_c_q, dq_e_q;
	logic [VAL_W+1:0]  t_c, t_e, span_x;
	logic [VAL_W-1:0]  q_c, q_e;

	logic              ok_q;
	logic [VAL_W-1:0]  curv_q, elev_q;

	// Entry fields.
	assign r_pos  = rdata_q[ENT_W-1 -: POS_W];
	assign r_c    = rdata_q[2*VAL_W-1 -: VAL_W];
	assign r_e    = rdata_q[VAL_W-1:0];
	assign p_pos  = prev_q[ENT_W-1 -: POS_W];
	assign p_c    = prev_q[2*VAL_W-1 -: VAL_W];
	assign p_e    = prev_q[VAL_W-1:0];
	assign e0_pos = e0_q[ENT_W-1 -: POS_W];
	assign e0_c   = e0_q[2*VAL_W-1 -: VAL_W];
	assign e0_e   = e0_q[VAL_W-1:0];

	// Effective node count, clamped to the table depth.
	always_comb begin
		if (32'(node_cnt_q) > 32'(MAX_NODES)) begin
			n_eff = CW'(MAX_NODES);
		end else begin
			n_eff = CW'(node_cnt_q);
		end
	end

	assign slot_ok = 32'(node_index) < 32'(MAX_NODES);

	// Status to the controller.
	assign sts.is_load   = (kind == KIND_LOAD);
	assign sts.tbl_ok    = (n_eff >= CW'(2)) && (track_len_q > MIN_TRACK_LENGTH);
	assign sts.gt        = r_pos > s_q;
	assign sts.idx_first = (idx_q == '0);
	assign sts.idx_last  = (idx_q == CW'(n_eff - CW'(1)));
	assign sts.span_ok   = !span_q[VAL_W] && (span_q != '0);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_len_q <= '0;
			node_cnt_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TRACK_LENGTH: track_len_q <= cfg_data;
				CFG_NODE_COUNT:   node_cnt_q  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Node memory with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.load_wr && slot_ok) begin
			mem_q[AW'(node_index)] <= {node_position, node_curvature, node_elevation};
		end
		if (cmd.mem_rd) begin
			rdata_q <= mem_q[idx_q[AW-1:0]];
		end
	end

	// Wrap divider: restoring remainder of the query magnitude by the loop length.
	assign mod_t = {mrem_q, mdq_q[QRY_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.qry_start) begin
			qneg_q <= query_position[QRY_W-1];
			mdq_q  <= query_position[QRY_W-1] ? -query_position : query_position;
			mrem_q <= '0;
		end else if (cmd.mod_step) begin
			if (mod_t >= {1'b0, track_len_q}) begin
				mrem_q <= LEN_W'(mod_t - {1'b0, track_len_q});
			end else begin
				mrem_q <= mod_t[LEN_W-1:0];
			end
			mdq_q <= {mdq_q[QRY_W-2:0], 1'b0};
		end
		if (cmd.mod_fix) begin
			s_q <= (qneg_q && mrem_q != '0) ? track_len_q - mrem_q : mrem_q;
		end
	end

	// Scan index.
	always_ff @(posedge clk) begin
		if (cmd.qry_start) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Scan registers: first node, lower node and upper bound of the segment.
	always_ff @(posedge clk) begin
		if (cmd.cmp_take) begin
			if (sts.idx_first) begin
				e0_q <= rdata_q;
			end
			if (sts.gt) begin
				up_pos_q <= {1'b0, r_pos};
				up_c_q   <= r_c;
				up_e_q   <= r_e;
			end else begin
				prev_q   <= rdata_q;
				up_pos_q <= {1'b0, track_len_q} + {1'b0, e0_pos};
				up_c_q   <= e0_c;
				up_e_q   <= e0_e;
			end
		end
	end

	// Segment setup: span, offset and value differences.
	assign span_w = {1'b0, up_pos_q} - {2'b00, p_pos};
	assign dv_c   = {up_c_q[VAL_W-1], up_c_q} - {p_c[VAL_W-1], p_c};
	assign dv_e   = {up_e_q[VAL_W-1], up_e_q} - {p_e[VAL_W-1], p_e};

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			span_q  <= span_w;
			off_q   <= s_q - p_pos;
			neg_c_q <= dv_c[VAL_W];
			neg_e_q <= dv_e[VAL_W];
			mag_c_q <= dv_c[VAL_W] ? -dv_c : dv_c;
			mag_e_q <= dv_e[VAL_W] ? -dv_e : dv_e;
		end
	end

	// Shift-add multipliers, one offset bit per cycle.
	always_ff @(posedge clk) begin
		if (cmd.mul_init) begin
			acc_c_q <= '0;
			acc_e_q <= '0;
			mc_c_q  <= 64'(mag_c_q);
			mc_e_q  <= 64'(mag_e_q);
			mpl_q   <= off_q;
		end else if (cmd.mul_step) begin
			if (mpl_q[0]) begin
				acc_c_q <= acc_c_q + mc_c_q;
				acc_e_q <= acc_e_q + mc_e_q;
			end
			mc_c_q <= {mc_c_q[62:0], 1'b0};
			mc_e_q <= {mc_e_q[62:0], 1'b0};
			mpl_q  <= {1'b0, mpl_q[POS_W-1:1]};
		end
	end

	// Restoring dividers by the span, one quotient bit per cycle.
	assign span_x = {1'b0, span_q};
	assign t_c    = {rem_c_q, dq_c_q[VAL_W]};
	assign t_e    = {rem_e_q, dq_e_q[VAL_W]};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_c_q <= (VAL_W + 1)'(acc_c_q[63:33]);
			rem_e_q <= (VAL_W + 1)'(acc_e_q[63:33]);
			dq_c_q  <= acc_c_q[32:0];
			dq_e_q  <= acc_e_q[32:0];
		end else if (cmd.div_step) begin
			if (t_c >= span_x) begin
				rem_c_q <= (VAL_W + 1)'(t_c - span_x);
				dq_c_q  <= {dq_c_q[VAL_W-1:0], 1'b1};
			end else begin
				rem_c_q <= t_c[VAL_W:0];
				dq_c_q  <= {dq_c_q[VAL_W-1:0], 1'b0};
			end
			if (t_e >= span_x) begin
				rem_e_q <= (VAL_W + 1)'(t_e - span_x);
				dq_e_q  <= {dq_e_q[VAL_W-1:0], 1'b1};
			end else begin
				rem_e_q <= t_e[VAL_W:0];
				dq_e_q  <= {dq_e_q[VAL_W-1:0], 1'b0};
			end
		end
	end

	// Signed quotients, truncated toward zero, wrapped to the value width.
	assign q_c = neg_c_q ? -dq_c_q[VAL_W-1:0] : dq_c_q[VAL_W-1:0];
	assign q_e = neg_e_q ? -dq_e_q[VAL_W-1:0] : dq_e_q[VAL_W-1:0];

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			case (cmd.res_src)
				RES_ZERO: begin
					ok_q   <= 1'b0;
					curv_q <= '0;
					elev_q <= '0;
				end
				RES_FIRST: begin
					ok_q   <= 1'b1;
					curv_q <= r_c;
					elev_q <= r_e;
				end
				RES_LOWER: begin
					ok_q   <= 1'b1;
					curv_q <= p_c;
					elev_q <= p_e;
				end
				default: begin
					ok_q   <= 1'b1;
					curv_q <= p_c + q_c;
					elev_q <= p_e + q_e;
				end
			endcase
		end
	end

	assign ok            = ok_q;
	assign curvature_out = curv_q;
	assign elevation_out = elev_q;

endmodule

### sv/periodic_profile_interpolator_unit.sv
// Periodic profile interpolator, top level.
// Joins the controller ppi_ctrl and the datapath ppi_dp; uses ppi_pkg.
//
// Usage:
//   The input channel carries one transaction per item. A load item
//   (kind = 0) writes node_position, node_curvature and node_elevation to
//   slot node_index and gives no result. A query item
//   (kind = 1) gives one result transaction with ok, curvature_out and
//   elevation_out.
//   The configuration channel (cfg_valid, cfg_index, cfg_data) is always
//   ready; index 0 is the track length, index 1 the active node count.
//   Write it only while the block is idle.
//   A query on an invalid table goes straight to its result, with ok = 0.
//   A valid query runs the wrap divider, scans the nodes one read at a
//   time on the single memory read port, then runs the multiply and the
//   divide. A query that stops at the first node or on an empty segment
//   skips the multiply and the divide. Items are worked one at a time.
//   The result sits in an output register; the next item is accepted while
//   it waits, and a finished query holds until that register is free.
//   Reset clears both registers to zero and empties the output. The node
//   table is not cleared; query only nodes that were loaded.
module periodic_profile_interpolator_unit #(
	parameter int MAX_NODES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic [ppi_pkg::IDX_W-1:0]         node_index,
	input  logic [ppi_pkg::POS_W-1:0]         node_position,
	input  logic signed [ppi_pkg::VAL_W-1:0]  node_curvature,
	input  logic signed [ppi_pkg::VAL_W-1:0]  node_elevation,
	input  logic signed [ppi_pkg::QRY_W-1:0]  query_position,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              ok,
	output logic signed [ppi_pkg::VAL_W-1:0]  curvature_out,
	output logic signed [ppi_pkg::VAL_W-1:0]  elevation_out,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ppi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ppi_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ppi_pkg::*;

	ppi_cmd_t cmd;
	ppi_sts_t sts;

	// Configuration writes are always accepted.
	assign cfg_ready = 1'b1;

	ppi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ppi_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.kind           (kind),
		.node_index     (node_index),
		.node_position  (node_position),
		.node_curvature (node_curvature),
		.node_elevation (node_elevation),
		.query_position (query_position),
		.ok             (ok),
		.curvature_out  (curvature_out),
		.elevation_out  (elevation_out),
		.cmd            (cmd),
		.sts            (sts)
	);

endmodule

### tb/tb_periodic_profile_interpolator_unit.sv
// Self-checking testbench for periodic_profile_interpolator_unit.
// Needs ppi_pkg and the RTL of the block; a scoreboard class predicts the
// results of queries from its own copy of the node table and registers.
`timescale 1ns / 1ps

module tb_periodic_profile_interpolator_unit;
	import ppi_pkg::*;

	localparam int NODE_SLOTS = 64;
	localparam int DRAIN_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD_CYCLES = 1500;
	localparam int NUM_PHASES = 12;
	localparam int ITEMS_PER_PHASE = 150;

	typedef struct {
		logic ok;
		logic signed [VAL_W-1:0] curv;
		logic signed [VAL_W-1:0] elev;
	} profile_sample_t;

	// Predicts profile samples and holds those still to come out.
	class profile_scoreboard;
		longint track_len;
		int node_cnt;
		logic [POS_W-1:0] pos_tbl [NODE_SLOTS];
		logic signed [VAL_W-1:0] curv_tbl [NODE_SLOTS];
		logic signed [VAL_W-1:0] elev_tbl [NODE_SLOTS];
		profile_sample_t pending [$];
		int mismatches;
		int samples_checked;
		int loads_seen;
		int queries_seen;

		function new();
			track_len = 0;
			node_cnt = 0;
			mismatches = 0;
			samples_checked = 0;
			loads_seen = 0;
			queries_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_TRACK_LENGTH)
				track_len = longint'(data);
			else
				node_cnt = int'(data[CNT_W-1:0]);
		endfunction

		function logic signed [VAL_W-1:0] lerp(longint v0, longint v1, longint off,
				longint span);
			longint prod;
			longint r;
			prod = (v1 - v0) * off;
			r = v0 + prod / span;
			return r[VAL_W-1:0];
		endfunction

		// Notes one accepted input transaction.
		function void note_item(logic k, logic [IDX_W-1:0] idx, logic [POS_W-1:0] pos,
				logic signed [VAL_W-1:0] curv, logic signed [VAL_W-1:0] elev,
				logic signed [QRY_W-1:0] qry);
			profile_sample_t smp;
			int n;
			int hi;
			int lo;
			longint s;
			longint s0;
			longint s1;
			longint span;
			if (k == KIND_LOAD) begin
				loads_seen++;
				pos_tbl[idx] = pos;
				curv_tbl[idx] = curv;
				elev_tbl[idx] = elev;
				return;
			end
			queries_seen++;
			n = (node_cnt > NODE_SLOTS) ? NODE_SLOTS : node_cnt;
			smp.ok = 1'b0;
			smp.curv = '0;
			smp.elev = '0;
			if (n >= 2 && track_len > longint'(MIN_TRACK_LENGTH)) begin
				smp.ok = 1'b1;
				s = longint'(qry) % track_len;
				if (s < 0)
					s += track_len;
				hi = n;
				for (int i = 0; i < n; i++) begin
					if (longint'(pos_tbl[i]) > s) begin
						hi = i;
						break;
					end
				end
				if (hi == 0) begin
					smp.curv = curv_tbl[0];
					smp.elev = elev_tbl[0];
				end else begin
					lo = hi - 1;
					s0 = longint'(pos_tbl[lo]);
					if (hi >= n) begin
						s1 = track_len + longint'(pos_tbl[0]);
						hi = 0;
					end else begin
						s1 = longint'(pos_tbl[hi]);
					end
					span = s1 - s0;
					if (span <= 0) begin
						smp.curv = curv_tbl[lo];
						smp.elev = elev_tbl[lo];
					end else begin
						smp.curv = lerp(longint'(curv_tbl[lo]), longint'(curv_tbl[hi]),
							s - s0, span);
						smp.elev = lerp(longint'(elev_tbl[lo]), longint'(elev_tbl[hi]),
							s - s0, span);
					end
				end
			end
			pending.push_back(smp);
		endfunction

		// Checks one result transaction against the oldest prediction.
		function void check_result(logic ok_a, logic signed [VAL_W-1:0] curv_a,
				logic signed [VAL_W-1:0] elev_a);
			profile_sample_t exp_s;
			samples_checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: ok=%0b curv=%0d elev=%0d",
						ok_a, curv_a, elev_a);
				return;
			end
			exp_s = pending.pop_front();
			if (ok_a !== exp_s.ok || curv_a !== exp_s.curv || elev_a !== exp_s.elev) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at %0t: exp ok=%0b curv=%0d elev=%0d, %s%0b %s%0d %s%0d",
						$realtime, exp_s.ok, exp_s.curv, exp_s.elev,
						"got ok=", ok_a, "curv=", curv_a, "elev=", elev_a);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic kind;
	logic [IDX_W-1:0] node_index;
	logic [POS_W-1:0] node_position;
	logic signed [VAL_W-1:0] node_curvature;
	logic signed [VAL_W-1:0] node_elevation;
	logic signed [QRY_W-1:0] query_position;
	logic out_valid;
	logic out_ready;
	logic ok;
	logic signed [VAL_W-1:0] curvature_out;
	logic signed [VAL_W-1:0] elevation_out;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	profile_scoreboard sb;
	int burst_left;
	bit gapless;
	bit hold_req;
	int idle_cycles = 0;
	logic [POS_W-1:0] node_pos_shadow [NODE_SLOTS];

	periodic_profile_interpolator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.node_index(node_index),
		.node_position(node_position),
		.node_curvature(node_curvature),
		.node_elevation(node_elevation),
		.query_position(query_position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ok(ok),
		.curvature_out(curvature_out),
		.elevation_out(elevation_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Monitor: every transaction is seen at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.note_item(kind, node_index, node_position, node_curvature,
					node_elevation, query_position);
			if (out_valid && out_ready)
				sb.check_result(ok, curvature_out, elevation_out);
		end
	end

	// Watchdog on cycles that move no transaction.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver: ready follows a pattern of random modes, with one long hold on request.
	initial begin : receiver
		int mode;
		int mode_left;
		int hold_left;
		bit hold_taken;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		hold_taken = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(10, 400);
				end
				mode_left--;
				case (mode)
					0: out_ready = 1'b1;
					1: out_ready = 1'($urandom_range(0, 1));
					default: out_ready = ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Offers one item; the sender may idle between bursts. Starts and ends at a falling edge.
	task automatic send_item(logic k, logic [IDX_W-1:0] idx, logic [POS_W-1:0] pos,
			logic signed [VAL_W-1:0] curv, logic signed [VAL_W-1:0] elev,
			logic signed [QRY_W-1:0] qry);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = gapless ? 0 : $urandom_range(0, 20);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		kind = k;
		node_index = idx;
		node_position = pos;
		node_curvature = curv;
		node_elevation = elev;
		query_position = qry;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic load_node(int idx, logic [POS_W-1:0] pos, logic signed [VAL_W-1:0] curv,
			logic signed [VAL_W-1:0] elev);
		node_pos_shadow[idx] = pos;
		send_item(KIND_LOAD, idx[IDX_W-1:0], pos, curv, elev, $urandom);
	endtask

	task automatic query(logic signed [QRY_W-1:0] qry);
		send_item(KIND_QUERY, IDX_W'($urandom), POS_W'($urandom), $urandom, $urandom, qry);
	endtask

	// Waits until every expected result has come and the block has settled.
	task automatic drain();
		in_valid = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_table(longint len, int cnt);
		drain();
		write_cfg(CFG_TRACK_LENGTH, len[CFG_DATA_W-1:0]);
		write_cfg(CFG_NODE_COUNT, cnt[CFG_DATA_W-1:0]);
	endtask

	// Loads m ascending nodes spread over a loop of length len.
	task automatic fill_ascending(longint len, int m);
		longint step;
		longint p;
		step = len / m;
		for (int i = 0; i < m; i++) begin
			p = i * step + $urandom_range(0, int'(step - 1));
			load_node(i, p[POS_W-1:0], $urandom, $urandom);
		end
	endtask

	initial begin : stimulus
		longint ph_len [NUM_PHASES];
		int ph_cnt [NUM_PHASES];
		longint len;
		longint q;
		int m;
		int sel;

		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_LOAD;
		node_index = '0;
		node_position = '0;
		node_curvature = '0;
		node_elevation = '0;
		query_position = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TRACK_LENGTH;
		cfg_data = '0;
		hold_req = 1'b0;
		burst_left = 0;
		gapless = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Queries on the table after reset are answered as invalid.
		query(32'sd0);
		query(32'sh7fffffff);

		// Write every slot once so no query can reach an unwritten one.
		for (int i = 0; i < NODE_SLOTS; i++)
			load_node(i, POS_W'(i * 1000 + 1000), $urandom, $urandom);

		// Directed part: four nodes with extreme values on a 250 m loop.
		set_table(64000, 4);
		load_node(0, 31'd1000, 32'sh7fffffff, 32'sh80000000);
		load_node(1, 31'd17000, 32'sh80000000, 32'sh7fffffff);
		load_node(2, 31'd33000, 32'sd0, -32'sd1);
		load_node(3, 31'd49000, 32'sd12345, -32'sd54321);
		query(32'sd0);
		query(32'sd999);
		query(32'sd1000);
		query(32'sd9000);
		query(32'sd17000);
		query(32'sd60000);
		query(32'sd63999);
		query(32'sd64000);
		query(-32'sd1);
		query(-32'sd64001);
		query(32'sh7fffffff);
		query(32'sh80000000);
		// Too few nodes, too short a loop and one just long enough, and a count beyond capacity.
		set_table(64000, 1);
		query(32'sd5000);
		set_table(64000, 0);
		query(32'sd5000);
		set_table(256, 4);
		query(32'sd100);
		set_table(257, 4);
		query(32'sd100);
		set_table(64000, 127);
		query(32'sd63000);
		query(-32'sd3);

		// Random phases over a spread of register settings.
		ph_len[0] = 25600;              ph_cnt[0] = 2;
		ph_len[1] = 32'h7fffffff;       ph_cnt[1] = 64;
		ph_len[2] = 257;                ph_cnt[2] = 3;
		ph_len[3] = 32'h7fffffff;       ph_cnt[3] = 2;
		ph_len[4] = 256;                ph_cnt[4] = 8;
		ph_len[5] = 100000;             ph_cnt[5] = 1;
		ph_len[6] = 0;                  ph_cnt[6] = 0;
		ph_len[7] = longint'($urandom_range(300, 32'h7fffffff));
		ph_cnt[7] = $urandom_range(65, 127);
		for (int ph = 8; ph < NUM_PHASES; ph++) begin
			ph_len[ph] = longint'($urandom_range(300, 32'h7fffffff));
			ph_cnt[ph] = $urandom_range(2, 12);
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			len = ph_len[ph];
			m = (ph_cnt[ph] > NODE_SLOTS) ? NODE_SLOTS : ph_cnt[ph];
			set_table(len, ph_cnt[ph]);
			gapless = (ph % 4 == 3);
			if (len > longint'(MIN_TRACK_LENGTH) && m >= 2)
				fill_ascending(len, m);
			if (ph == 2)
				hold_req = 1'b1;
			for (int it = 0; it < ITEMS_PER_PHASE; it++) begin
				// A pause of the sender until every result has come.
				if (ph == 4 && it == ITEMS_PER_PHASE / 2) begin
					in_valid = 1'b0;
					while (sb.pending.size() != 0) @(negedge clk);
				end
				sel = $urandom_range(0, 99);
				if (sel < 4) begin
					// Noise: a load of random content to any slot.
					load_node($urandom_range(0, NODE_SLOTS - 1), POS_W'($urandom),
						$urandom, $urandom);
				end else if (sel < 10 && m >= 2) begin
					// Fresh values at a used slot, position kept in order.
					sel = $urandom_range(0, m - 1);
					load_node(sel, node_pos_shadow[sel], $urandom, $urandom);
				end else begin
					case ($urandom_range(0, 3))
						0: q = longint'($signed($urandom));
						1: q = (len > 1) ? $urandom_range(0, int'(len - 1)) : 0;
						2: q = (len > 1) ? $urandom_range(0, int'(len - 1))
							+ ($urandom_range(0, 2) - 1) * len : 0;
						default: q = longint'(node_pos_shadow[$urandom_range(0,
							(m > 0) ? m - 1 : 0)]);
					endcase
					query(q[QRY_W-1:0]);
				end
			end
		end

		drain();
		$display("covered %0d loads and %0d queries over %0d register settings;",
			sb.loads_seen, sb.queries_seen, NUM_PHASES + 6);
		$display("%0d results checked, with invalid tables, wrap-around and a long output hold",
			sb.samples_checked);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
